>>> rtl/enhanced_clock_replacement_unit_assert.svh
// Assertion macros shared by the checkers of the clock replacement unit.
// Expects clk_i and rst_ni in the scope of each use.
`ifndef ENHANCED_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH
`define ENHANCED_CLOCK_REPLACEMENT_UNIT_ASSERT_SVH

// same-cycle implication
`define ECR_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ecr assertion failed");

// next-cycle implication
`define ECR_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("ecr assertion failed");

`endif

>>> rtl/ecr_pkg.sv
// Package of the clock replacement unit: widths, codes and the
// controller/datapath command and status structs. No dependencies.
package ecr_pkg;

  localparam int unsigned FRAMES     = 16;
  localparam int unsigned IDX_W      = $clog2(FRAMES);
  localparam int unsigned CNT_W      = $clog2(FRAMES + 1);
  localparam int unsigned OP_W       = 2;
  localparam int unsigned FRAME_W    = 4;
  localparam int unsigned PAGE_W     = 20;
  localparam int unsigned SWAP_W     = 28;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned SWAP_SHIFT = 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSTALL = 2'd0,
    OP_ACCESS  = 2'd1,
    OP_EVICT   = 2'd2,
    OP_NOP     = 2'd3
  } op_e;

  typedef enum logic [KIND_W-1:0] {
    KIND_WB     = 2'd0,
    KIND_VICTIM = 2'd1,
    KIND_ACK    = 2'd2,
    KIND_ERR    = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    RES_INSTALL = 3'd0,
    RES_ACCESS  = 3'd1,
    RES_NULL    = 3'd2,
    RES_ERR     = 3'd3,
    RES_WB      = 3'd4,
    RES_VICTIM  = 3'd5
  } res_e;

  typedef struct packed {
    logic item_load;
    logic install;
    logic access;
    logic evict_start;
    logic clr_ref;
    logic clr_dirty;
    logic advance;
    logic commit_victim;
    logic rd_pos;
    logic rd_frame;
    logic out_load;
    res_e res_sel;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic empty;
    logic install_full;
    logic cur_ref;
    logic cur_dirty;
    logic out_free;
  } stat_t;

endpackage

>>> rtl/ecr_if.sv
// Valid/ready channel interfaces of the clock replacement unit.
// Depends on ecr_pkg.
interface ecr_in_if;
  logic                        valid;
  logic                        ready;
  logic [ecr_pkg::OP_W-1:0]    op;
  logic [ecr_pkg::FRAME_W-1:0] frame;
  logic [ecr_pkg::PAGE_W-1:0]  page_number;
  logic                        is_write;

  modport source (output valid, op, frame, page_number, is_write, input ready);
  modport sink   (input valid, op, frame, page_number, is_write, output ready);
endinterface

interface ecr_out_if;
  logic                        valid;
  logic                        ready;
  logic [ecr_pkg::KIND_W-1:0]  kind;
  logic [ecr_pkg::FRAME_W-1:0] frame_out;
  logic [ecr_pkg::PAGE_W-1:0]  page_out;
  logic [ecr_pkg::SWAP_W-1:0]  swap_entry;
  logic                        last;

  modport source (output valid, kind, frame_out, page_out, swap_entry, last, input ready);
  modport sink   (input valid, kind, frame_out, page_out, swap_entry, last, output ready);
endinterface

>>> rtl/ecr_ctrl.sv
// Controller state machine of the clock replacement unit.
// Depends on ecr_pkg; drives ecr_datapath through cmd_t, reads stat_t.
module ecr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  ecr_pkg::stat_t stat_i,
  output ecr_pkg::cmd_t  cmd_o
);
  import ecr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_DECODE = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_EMIT   = 4'b1000
  } state_e;

  state_e state_q, state_d;
  res_e   res_q, res_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    res_d   = res_q;
    cmd_o   = '0;
    cmd_o.res_sel = res_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        state_d = ST_EMIT;
        unique case (stat_i.op)
          OP_INSTALL: begin
            if (stat_i.install_full) begin
              res_d = RES_ERR;
            end else begin
              cmd_o.install = 1'b1;
              res_d = RES_INSTALL;
            end
          end
          OP_ACCESS: begin
            cmd_o.access   = 1'b1;
            cmd_o.rd_frame = 1'b1;
            res_d = RES_ACCESS;
          end
          OP_EVICT: begin
            if (stat_i.empty) begin
              res_d = RES_ERR;
            end else begin
              cmd_o.evict_start = 1'b1;
              state_d = ST_SCAN;
            end
          end
          default: res_d = RES_NULL;
        endcase
      end
      ST_SCAN: begin
        if (!stat_i.cur_ref && !stat_i.cur_dirty) begin
          cmd_o.rd_pos        = 1'b1;
          cmd_o.commit_victim = 1'b1;
          res_d   = RES_VICTIM;
          state_d = ST_EMIT;
        end else if (stat_i.cur_ref) begin
          cmd_o.clr_ref = 1'b1;
          cmd_o.advance = 1'b1;
        end else begin
          cmd_o.clr_dirty = 1'b1;
          cmd_o.rd_pos    = 1'b1;
          res_d   = RES_WB;
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          if (res_q == RES_WB) begin
            cmd_o.advance = 1'b1;
            state_d = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      res_q   <= RES_NULL;
    end else begin
      state_q <= state_d;
      res_q   <= res_d;
    end
  end

endmodule

>>> rtl/ecr_datapath.sv
// Datapath of the clock replacement unit: item latch, page store, bit
// vectors, ring counters, sweep position and output register. Uses ecr_pkg.
module ecr_datapath (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [ecr_pkg::OP_W-1:0]    op_i,
  input  logic [ecr_pkg::FRAME_W-1:0] frame_i,
  input  logic [ecr_pkg::PAGE_W-1:0]  page_number_i,
  input  logic                        is_write_i,
  input  ecr_pkg::cmd_t               cmd_i,
  output ecr_pkg::stat_t              stat_o,
  input  logic                        out_ready_i,
  output logic                        out_valid_o,
  output logic [ecr_pkg::KIND_W-1:0]  kind_o,
  output logic [ecr_pkg::FRAME_W-1:0] frame_out_o,
  output logic [ecr_pkg::PAGE_W-1:0]  page_out_o,
  output logic [ecr_pkg::SWAP_W-1:0]  swap_entry_o,
  output logic                        last_o
);
  import ecr_pkg::*;

  logic [OP_W-1:0]    op_q;
  logic [FRAME_W-1:0] frame_q;
  logic [PAGE_W-1:0]  page_q;
  logic               wr_q;

  logic [PAGE_W-1:0]  page_mem [FRAMES];
  logic [PAGE_W-1:0]  rd_q;
  logic [FRAMES-1:0]  ref_q, dirty_q;
  logic [CNT_W-1:0]   used_q;
  logic [IDX_W-1:0]   hand_q, pos_q, last_victim_q, slot_q;
  logic               frozen_q, in_ring_q;

  logic               out_valid_q, out_last_q;
  kind_e              out_kind_q;
  logic [FRAME_W-1:0] out_frame_q;
  logic [PAGE_W-1:0]  out_page_q, page_plus1;
  logic [SWAP_W-1:0]  out_swap_q;

  logic [IDX_W-1:0]   slot_d, next_pos, rd_addr, frame_idx;
  logic [CNT_W-1:0]   pos_inc;
  logic               in_ring, out_free;

  assign frame_idx = IDX_W'(frame_q);
  assign in_ring   = (CNT_W'(frame_q) < used_q);
  assign slot_d    = frozen_q ? last_victim_q : IDX_W'(used_q);
  assign pos_inc   = CNT_W'(pos_q) + CNT_W'(1);
  assign next_pos  = (pos_inc < used_q) ? IDX_W'(pos_inc) : '0;
  assign rd_addr   = cmd_i.rd_pos ? pos_q : frame_idx;
  assign out_free  = !out_valid_q || out_ready_i;
  assign page_plus1 = rd_q + PAGE_W'(1);

  assign stat_o.op           = op_e'(op_q);
  assign stat_o.empty        = (used_q == '0);
  assign stat_o.install_full = !frozen_q && (used_q >= CNT_W'(FRAMES));
  assign stat_o.cur_ref      = ref_q[pos_q];
  assign stat_o.cur_dirty    = dirty_q[pos_q];
  assign stat_o.out_free     = out_free;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q    <= op_i;
      frame_q <= frame_i;
      page_q  <= page_number_i;
      wr_q    <= is_write_i;
    end
    if (cmd_i.install) begin
      page_mem[slot_d] <= page_q;
      slot_q           <= slot_d;
    end
    if (cmd_i.rd_pos || cmd_i.rd_frame) begin
      rd_q <= page_mem[rd_addr];
    end
    if (cmd_i.access) begin
      in_ring_q <= in_ring;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_q         <= '0;
      dirty_q       <= '0;
      used_q        <= '0;
      hand_q        <= '0;
      pos_q         <= '0;
      last_victim_q <= '0;
      frozen_q      <= 1'b0;
    end else begin
      if (cmd_i.install) begin
        ref_q[slot_d]   <= 1'b0;
        dirty_q[slot_d] <= 1'b0;
        if (!frozen_q) begin
          used_q <= used_q + CNT_W'(1);
        end
      end
      if (cmd_i.access && in_ring) begin
        ref_q[frame_idx] <= 1'b1;
        if (wr_q) begin
          dirty_q[frame_idx] <= 1'b1;
        end
      end
      if (cmd_i.evict_start) begin
        frozen_q <= 1'b1;
        pos_q    <= (CNT_W'(hand_q) < used_q) ? hand_q : '0;
      end
      if (cmd_i.clr_ref) begin
        ref_q[pos_q] <= 1'b0;
      end
      if (cmd_i.clr_dirty) begin
        dirty_q[pos_q] <= 1'b0;
      end
      if (cmd_i.advance) begin
        pos_q <= next_pos;
      end
      if (cmd_i.commit_victim) begin
        last_victim_q <= pos_q;
        hand_q        <= next_pos;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_swap_q <= '0;
      out_last_q <= 1'b1;
      case (cmd_i.res_sel)
        RES_INSTALL: begin
          out_kind_q  <= KIND_ACK;
          out_frame_q <= FRAME_W'(slot_q);
          out_page_q  <= page_q;
        end
        RES_ACCESS: begin
          out_kind_q  <= KIND_ACK;
          out_frame_q <= frame_q;
          out_page_q  <= in_ring_q ? rd_q : '0;
        end
        RES_WB: begin
          out_kind_q  <= KIND_WB;
          out_frame_q <= FRAME_W'(pos_q);
          out_page_q  <= rd_q;
          out_swap_q  <= {page_plus1[SWAP_W-SWAP_SHIFT-1:0], SWAP_SHIFT'(0)};
          out_last_q  <= 1'b0;
        end
        RES_VICTIM: begin
          out_kind_q  <= KIND_VICTIM;
          out_frame_q <= FRAME_W'(pos_q);
          out_page_q  <= rd_q;
        end
        RES_ERR: begin
          out_kind_q  <= KIND_ERR;
          out_frame_q <= '0;
          out_page_q  <= '0;
        end
        default: begin
          out_kind_q  <= KIND_ACK;
          out_frame_q <= '0;
          out_page_q  <= '0;
        end
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign kind_o       = out_kind_q;
  assign frame_out_o  = out_frame_q;
  assign page_out_o   = out_page_q;
  assign swap_entry_o = out_swap_q;
  assign last_o       = out_last_q;

endmodule

>>> rtl/enhanced_clock_replacement_unit.sv
// Install, access and no-op go from decode to emit, where their result is registered once the output is free.
// Eviction sweeps from the hand: a referenced frame has its bit cleared, a dirty one is
// written back, a clean unreferenced one is the victim; output stalls can hold each result.
// Throughput: one item at a time, the next accepted once its last result is registered.
// Reset clears bits, counts, hand, frozen flag and output valid; page store not cleared.
module enhanced_clock_replacement_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  ecr_in_if.sink    in_i,
  ecr_out_if.source out_o
);
  import ecr_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ecr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ecr_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (in_i.op),
    .frame_i       (in_i.frame),
    .page_number_i (in_i.page_number),
    .is_write_i    (in_i.is_write),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_ready_i   (out_o.ready),
    .out_valid_o   (out_o.valid),
    .kind_o        (out_o.kind),
    .frame_out_o   (out_o.frame_out),
    .page_out_o    (out_o.page_out),
    .swap_entry_o  (out_o.swap_entry),
    .last_o        (out_o.last)
  );

endmodule

>>> rtl/ecr_checker.sv
// Port-level checker of the clock replacement unit, bound to the top level.
// Depends on ecr_pkg and enhanced_clock_replacement_unit_assert.svh.
`include "enhanced_clock_replacement_unit_assert.svh"

module ecr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [ecr_pkg::KIND_W-1:0]  kind_i,
  input logic [ecr_pkg::FRAME_W-1:0] frame_out_i,
  input logic [ecr_pkg::PAGE_W-1:0]  page_out_i,
  input logic [ecr_pkg::SWAP_W-1:0]  swap_entry_i,
  input logic                        last_i
);
  import ecr_pkg::*;

  logic [PAGE_W-1:0] page_inc;
  assign page_inc = page_out_i + PAGE_W'(1);

  `ECR_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i && $stable(kind_i) && $stable(page_out_i))
  `ECR_ASSERT_NXT(a_one_in_flight, in_valid_i && in_ready_i, !in_ready_i)
  `ECR_ASSERT_IMP(a_err_zero, out_valid_i && kind_i == KIND_ERR, last_i && frame_out_i == '0 && page_out_i == '0 && swap_entry_i == '0)
  `ECR_ASSERT_IMP(a_wb_swap, out_valid_i && kind_i == KIND_WB, !last_i && swap_entry_i == {page_inc[SWAP_W-SWAP_SHIFT-1:0], SWAP_SHIFT'(0)})
  `ECR_ASSERT_IMP(a_other_last, out_valid_i && kind_i != KIND_WB, last_i && swap_entry_i == '0)

endmodule

bind enhanced_clock_replacement_unit ecr_checker u_ecr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .kind_i       (out_o.kind),
  .frame_out_i  (out_o.frame_out),
  .page_out_i   (out_o.page_out),
  .swap_entry_i (out_o.swap_entry),
  .last_i       (out_o.last)
);
